// ----- rtl/sof_pkg.sv -----
// ----------------------------------------------------------------------------
// sof_pkg
// shared widths, register indexes and types of the substring occurrence
// finder
// ----------------------------------------------------------------------------
package sof_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 5;
    localparam int PAT_BYTES   = 16;
    localparam int PAT_SEL_W   = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int OUT_POS_W   = 32;
    localparam int TALLY_W     = 16;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

    typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern_t;

    // window compare status handed from the cell row to the tracker
    typedef struct packed {
        logic             window_ok;
        logic [LEN_W-1:0] len;
    } sof_cmp_t;

endpackage

// ----- rtl/sof_if.sv -----
// ----------------------------------------------------------------------------
// sof_if
// valid/ready channels of the finder: text bytes in, match results out
// ----------------------------------------------------------------------------
interface sof_text_if;
    logic                       valid;
    logic                       ready;
    logic [sof_pkg::BYTE_W-1:0] text_byte;
    logic                       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface sof_result_if;
    logic                          valid;
    logic                          ready;
    logic                          match_found;
    logic [sof_pkg::OUT_POS_W-1:0] match_start;
    logic [sof_pkg::OUT_POS_W-1:0] match_end;
    logic [sof_pkg::TALLY_W-1:0]   occurrence_total;
    logic                          text_done;

    modport source (
        output valid, output match_found, output match_start, output match_end,
        output occurrence_total, output text_done, input ready
    );
    modport sink (
        input valid, input match_found, input match_start, input match_end,
        input occurrence_total, input text_done, output ready
    );
endinterface

// ----- rtl/sof_cell.sv -----
// ----------------------------------------------------------------------------
// sof_cell
// one window cell: compares the byte it sees against its pattern byte and
// holds that byte for the next cell
// ----------------------------------------------------------------------------
module sof_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                         clk,
    input  logic                         advance,
    input  logic [sof_pkg::BYTE_W-1:0]   byte_in,
    input  sof_pkg::pattern_t            pattern,
    input  logic [sof_pkg::LEN_W-1:0]    len,
    output logic [sof_pkg::BYTE_W-1:0]   byte_out,
    output logic                         ok
);

    localparam logic [sof_pkg::LEN_W-1:0] IDX = sof_pkg::LEN_W'(CELL_INDEX);

    logic [sof_pkg::BYTE_W-1:0] byte_reg;
    logic [sof_pkg::LEN_W-1:0]  sel;
    logic                       active;

    // cell k lines up with pattern byte len-1-k
    assign active = (len > IDX);
    assign sel    = len - IDX - sof_pkg::LEN_W'(1);
    assign ok     = !active || (byte_in == pattern[sel[sof_pkg::PAT_SEL_W-1:0]]);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

endmodule

// ----- rtl/sof_tracker.sv -----
// ----------------------------------------------------------------------------
// sof_tracker
// byte position, overlap guard and match tally; builds each result and holds
// it in the output register
// ----------------------------------------------------------------------------
module sof_tracker #(
    parameter int POSITION_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 end_of_text,
    input  sof_pkg::sof_cmp_t    cmp,
    output logic                 in_ready,
    sof_result_if.source         result
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [POSITION_BITS-1:0]      pos_reg, pos_next;
    logic [sof_pkg::LEN_W-1:0]     guard_reg, guard_next;
    logic [sof_pkg::TALLY_W-1:0]   tally_reg, tally_next, tally_inc;
    logic                          valid_reg, valid_next;
    logic                          found_reg;
    logic [sof_pkg::OUT_POS_W-1:0] start_reg, end_reg;
    logic [sof_pkg::TALLY_W-1:0]   total_reg;
    logic                          done_reg;

    logic [sof_pkg::LEN_W-1:0]     len_m1;
    logic [POSITION_BITS-1:0]      start_pos;
    logic [sof_pkg::OUT_POS_W-1:0] start_out, end_out;
    logic                          hit;
    logic                          emit;

    assign len_m1    = cmp.len - sof_pkg::LEN_W'(1);
    assign hit       = (guard_reg == '0) && (cmp.len != '0)
                     && (pos_reg >= POSITION_BITS'(len_m1)) && cmp.window_ok;
    assign start_pos = pos_reg - POSITION_BITS'(len_m1);
    assign tally_inc = (hit && tally_reg != sof_pkg::TALLY_MAX)
                     ? tally_reg + sof_pkg::TALLY_W'(1) : tally_reg;
    assign emit      = hit || end_of_text;

    generate
        if (POSITION_BITS >= sof_pkg::OUT_POS_W)
        begin : g_pos_trunc
            assign start_out = start_pos[sof_pkg::OUT_POS_W-1:0];
            assign end_out   = pos_reg[sof_pkg::OUT_POS_W-1:0];
        end
        else
        begin : g_pos_ext
            assign start_out = {{(sof_pkg::OUT_POS_W-POSITION_BITS){1'b0}}, start_pos};
            assign end_out   = {{(sof_pkg::OUT_POS_W-POSITION_BITS){1'b0}}, pos_reg};
        end
    endgenerate

    // a new byte enters whenever the output register is free or being drained
    assign in_ready = !valid_reg || result.ready;

    always_comb
    begin
        pos_next   = pos_reg;
        guard_next = guard_reg;
        tally_next = tally_reg;
        valid_next = valid_reg && !result.ready;
        if (accept)
        begin
            valid_next = emit;
            if (end_of_text)
            begin
                pos_next   = '0;
                guard_next = '0;
                tally_next = '0;
            end
            else
            begin
                pos_next   = (pos_reg != POS_MAX) ? pos_reg + POSITION_BITS'(1) : pos_reg;
                tally_next = tally_inc;
                if (hit)
                begin
                    guard_next = len_m1;
                end
                else if (guard_reg != '0)
                begin
                    guard_next = guard_reg - sof_pkg::LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            guard_reg <= '0;
            tally_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            guard_reg <= guard_next;
            tally_reg <= tally_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            found_reg <= hit;
            start_reg <= hit ? start_out : '0;
            end_reg   <= hit ? end_out : '0;
            total_reg <= tally_inc;
            done_reg  <= end_of_text;
        end
    end

    assign result.valid            = valid_reg;
    assign result.match_found      = found_reg;
    assign result.match_start      = start_reg;
    assign result.match_end        = end_reg;
    assign result.occurrence_total = total_reg;
    assign result.text_done        = done_reg;

    a_guard_blocks_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (guard_reg != '0) |-> !hit)
        else $error("match reported inside overlap guard");

    a_hit_sets_guard: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && hit && !end_of_text) |=> (guard_reg == $past(len_m1)))
        else $error("guard not loaded after match");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_text) |=> (pos_reg == '0 && tally_reg == '0 && guard_reg == '0))
        else $error("text state not cleared after last byte");

    a_tally_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !end_of_text) |=> (tally_reg >= $past(tally_reg)))
        else $error("tally went down within a text");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> valid_reg)
        else $error("input stalled with empty output register");

endmodule

// ----- rtl/substring_occurrence_finder.sv -----
// ----------------------------------------------------------------------------
// substring_occurrence_finder
// streaming search for leftmost non-overlapping occurrences of a configured
// pattern in a byte text
// ----------------------------------------------------------------------------
// Takes one text byte per clock cycle, sustained, and a byte's result (when
// it has one) is valid on the result channel the cycle after the byte is
// taken. A row of PATTERN_MAX cells holds the last bytes of the text and
// compares the whole window against the pattern in the same cycle the new
// byte arrives; the tracker then updates position, overlap guard and tally.
// The result sits in a single output register, and the text channel stalls
// only while that register is full and the result channel is not taking it.
// Configuration writes take effect on the next byte; write them between
// texts.
// ----------------------------------------------------------------------------
module substring_occurrence_finder #(
    parameter int PATTERN_MAX   = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sof_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sof_pkg::CFG_DATA_W-1:0]    cfg_data,
    sof_text_if.sink                          text,
    sof_result_if.source                      result
);

    logic [sof_pkg::LEN_W-1:0]      pattern_length_reg;
    logic [sof_pkg::CFG_DATA_W-1:0] pattern_low_reg;
    logic [sof_pkg::CFG_DATA_W-1:0] pattern_high_reg;

    sof_pkg::pattern_t               pattern;
    logic [sof_pkg::LEN_W-1:0]       len_eff;
    logic [PATTERN_MAX:0][sof_pkg::BYTE_W-1:0] byte_chain;
    logic [PATTERN_MAX-1:0]          cell_ok;
    logic                            accept;
    logic                            in_ready;
    sof_pkg::sof_cmp_t               cmp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sof_pkg::CFG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[sof_pkg::LEN_W-1:0];
                sof_pkg::CFG_PATTERN_LOW:
                    pattern_low_reg <= cfg_data;
                sof_pkg::CFG_PATTERN_HIGH:
                    pattern_high_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    assign pattern = {pattern_high_reg, pattern_low_reg};

    // lengths beyond the window are used as the full window
    assign len_eff = (pattern_length_reg > sof_pkg::LEN_W'(PATTERN_MAX))
                   ? sof_pkg::LEN_W'(PATTERN_MAX) : pattern_length_reg;

    assign accept     = text.valid && in_ready;
    assign text.ready = in_ready;

    assign byte_chain[0] = text.text_byte;

    generate
        for (genvar k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            sof_cell #(
                .CELL_INDEX (k)
            ) u_cell (
                .clk      (clk),
                .advance  (accept),
                .byte_in  (byte_chain[k]),
                .pattern  (pattern),
                .len      (len_eff),
                .byte_out (byte_chain[k+1]),
                .ok       (cell_ok[k])
            );
        end
    endgenerate

    assign cmp.window_ok = &cell_ok;
    assign cmp.len       = len_eff;

    sof_tracker #(
        .POSITION_BITS (POSITION_BITS)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .end_of_text (text.end_of_text),
        .cmp         (cmp),
        .in_ready    (in_ready),
        .result      (result)
    );

endmodule

// ----- tb/substring_occurrence_finder_tb.sv -----
// ----------------------------------------------------------------------------
// substring_occurrence_finder_tb
// self-checking bench for the streaming substring occurrence finder
// ----------------------------------------------------------------------------
// Streams text bytes through the valid/ready text channel and checks every
// result transaction against a cycle-free software search that mirrors the
// window, position, overlap guard and tally of the block. Directed texts
// cover the empty pattern, a mismatch that must not drop a byte, zero bytes,
// overlapping occurrences and an oversized length. Random texts are built
// mostly from pattern copies and pattern symbols under changing patterns,
// some phases ending mid-text.
// ----------------------------------------------------------------------------
module substring_occurrence_finder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [sof_pkg::BYTE_W-1:0] data;
        logic                       last;
    } text_item_t;

    typedef struct packed {
        logic                          found;
        logic [sof_pkg::OUT_POS_W-1:0] first_pos;
        logic [sof_pkg::OUT_POS_W-1:0] last_pos;
        logic [sof_pkg::TALLY_W-1:0]   total;
        logic                          done;
    } match_report_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b1;
    logic                            cfg_we    = 1'b0;
    logic [sof_pkg::CFG_INDEX_W-1:0] cfg_index = sof_pkg::CFG_PATTERN_LENGTH;
    logic [sof_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    sof_text_if   text_ch ();
    sof_result_if result_ch ();

    substring_occurrence_finder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .text      (text_ch),
        .result    (result_ch)
    );

    always #1 clk = ~clk;

    // mirrored search state and pattern registers
    logic [sof_pkg::LEN_W-1:0]      pat_len;
    logic [sof_pkg::CFG_DATA_W-1:0] pat_low;
    logic [sof_pkg::CFG_DATA_W-1:0] pat_high;
    logic [sof_pkg::BYTE_W-1:0]     window [sof_pkg::PAT_BYTES];
    logic [31:0]                    seen_count;
    int unsigned                    guard_left;
    logic [sof_pkg::TALLY_W-1:0]    tally;

    text_item_t    text_to_send [$];
    match_report_t match_reports_due [$];
    text_item_t    item_on_bus;
    int unsigned   bytes_queued      = 0;
    int unsigned   bytes_taken       = 0;
    int unsigned   sender_idle_pct   = 20;
    int unsigned   receiver_idle_pct = 51;
    int unsigned   mismatches        = 0;

    function automatic logic [sof_pkg::BYTE_W-1:0] pattern_byte(int unsigned i);
        if (i < 8)
            return pat_low[8*i +: 8];
        return pat_high[8*(i-8) +: 8];
    endfunction

    function automatic string describe_report(match_report_t r);
        return $sformatf("found=%0b start=%0d end=%0d total=%0d done=%0b",
                         r.found, r.first_pos, r.last_pos, r.total, r.done);
    endfunction

    task automatic clear_text();
        for (int i = 0; i < sof_pkg::PAT_BYTES; i++)
            window[i] = '0;
        seen_count = '0;
        guard_left = 0;
        tally      = '0;
    endtask

    // one text byte through the search; queues the report it causes, if any
    task automatic advance_search(input text_item_t item);
        int unsigned   len;
        int unsigned   k;
        logic          hit;
        logic [31:0]   pos;
        match_report_t rep;
        len = (pat_len > sof_pkg::PAT_BYTES) ? sof_pkg::PAT_BYTES : pat_len;
        pos = seen_count;
        hit = 1'b0;
        if (guard_left != 0)
            guard_left--;
        else if (len != 0 && seen_count >= len - 1)
        begin
            hit = (pattern_byte(len - 1) == item.data);
            for (k = 1; k < len; k++)
                if (pattern_byte(len - 1 - k) != window[k - 1])
                    hit = 1'b0;
        end
        if (hit)
        begin
            guard_left = len - 1;
            if (tally != sof_pkg::TALLY_MAX)
                tally++;
        end
        // newest byte first
        for (k = sof_pkg::PAT_BYTES - 1; k > 0; k--)
            window[k] = window[k - 1];
        window[0] = item.data;
        if (seen_count != '1)
            seen_count++;
        if (hit || item.last)
        begin
            rep.found     = hit;
            rep.first_pos = hit ? pos - (len - 1) : '0;
            rep.last_pos  = hit ? pos : '0;
            rep.total     = tally;
            rep.done      = item.last;
            match_reports_due.push_back(rep);
        end
        if (item.last)
            clear_text();
    endtask

    task automatic check_report();
        match_report_t got;
        match_report_t want;
        got.found     = result_ch.match_found;
        got.first_pos = result_ch.match_start;
        got.last_pos  = result_ch.match_end;
        got.total     = result_ch.occurrence_total;
        got.done      = result_ch.text_done;
        if (match_reports_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result transaction: %s", $time, describe_report(got));
        end
        else
        begin
            want = match_reports_due.pop_front();
            if (got.found !== want.found || got.first_pos !== want.first_pos ||
                got.last_pos !== want.last_pos || got.total !== want.total ||
                got.done !== want.done)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: mismatch, expected %s", $time, describe_report(want));
                    $display("%0t:           actual   %s", $time, describe_report(got));
                end
            end
        end
    endtask

    task automatic queue_byte(input logic [sof_pkg::BYTE_W-1:0] data, input logic last);
        text_item_t item;
        item.data = data;
        item.last = last;
        text_to_send.push_back(item);
        bytes_queued++;
    endtask

    // called right after a rising edge; leaves cfg_we falling at the last write
    task automatic write_registers(input logic [sof_pkg::CFG_DATA_W-1:0] len_word,
                                   input logic [sof_pkg::CFG_DATA_W-1:0] low_word,
                                   input logic [sof_pkg::CFG_DATA_W-1:0] high_word);
        cfg_we    <= 1'b1;
        cfg_index <= sof_pkg::CFG_PATTERN_LENGTH;
        cfg_data  <= len_word;
        @(posedge clk);
        cfg_index <= sof_pkg::CFG_PATTERN_LOW;
        cfg_data  <= low_word;
        @(posedge clk);
        cfg_index <= sof_pkg::CFG_PATTERN_HIGH;
        cfg_data  <= high_word;
        @(posedge clk);
        cfg_we   <= 1'b0;
        pat_len  = len_word[sof_pkg::LEN_W-1:0];
        pat_low  = low_word;
        pat_high = high_word;
    endtask

    // all bytes taken, all reports in, then a short wait so that a byte with no result also settles
    task automatic wait_quiet();
        while (bytes_taken != bytes_queued || match_reports_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // text driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_ch.valid       <= 1'b0;
            text_ch.text_byte   <= '0;
            text_ch.end_of_text <= 1'b0;
        end
        else
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                advance_search(item_on_bus);
                bytes_taken++;
            end
            if (!text_ch.valid || text_ch.ready)
            begin
                if (text_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    item_on_bus = text_to_send.pop_front();
                    text_ch.valid       <= 1'b1;
                    text_ch.text_byte   <= item_on_bus.data;
                    text_ch.end_of_text <= item_on_bus.last;
                end
                else
                    text_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
                check_report();
            result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    initial
    begin
        logic [sof_pkg::BYTE_W-1:0]     pat_bytes [sof_pkg::PAT_BYTES];
        logic [sof_pkg::BYTE_W-1:0]     sym [3];
        logic [sof_pkg::BYTE_W-1:0]     data;
        logic [sof_pkg::CFG_DATA_W-1:0] len_word;
        logic [sof_pkg::CFG_DATA_W-1:0] low_word;
        logic [sof_pkg::CFG_DATA_W-1:0] high_word;
        int unsigned                    new_len;
        int unsigned                    eff_len;
        int unsigned                    num_syms;
        int unsigned                    copy_left;
        int unsigned                    copy_idx;
        int unsigned                    text_left;

        pat_len  = '0;
        pat_low  = '0;
        pat_high = '0;
        clear_text();
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern straight out of reset
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        wait_quiet();

        // 'aab' in 'aaab': the mismatching byte starts the next try
        write_registers(64'd3, 64'h62_61_61, '0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h62, 1'b1);
        wait_quiet();

        // zero-byte pattern, overlapping candidates; junk above the length field
        write_registers(64'hFFFF_FFFF_FFFF_FFE2, '0, '0);
        repeat (4) queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        wait_quiet();

        // length field all ones clamps to the full pattern
        write_registers('1, '1, '1);
        for (int n = 0; n < sof_pkg::PAT_BYTES; n++)
            queue_byte(8'hFF, n == sof_pkg::PAT_BYTES - 1);
        wait_quiet();

        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase == 4)
            begin
                sender_idle_pct   = 51;
                receiver_idle_pct = 20;
            end
            else if (phase == 8)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end

            case ($urandom_range(9))
                0:       new_len = 0;
                1:       new_len = sof_pkg::PAT_BYTES;
                2:       new_len = $urandom_range(31, sof_pkg::PAT_BYTES + 1);
                default: new_len = $urandom_range(1, 6);
            endcase
            len_word = ($urandom_range(3) == 0) ? {$urandom, $urandom} : '0;
            len_word[sof_pkg::LEN_W-1:0] = sof_pkg::LEN_W'(new_len);

            // small alphabet so that matches and overlaps are frequent
            sym[0] = sof_pkg::BYTE_W'($urandom_range(255));
            sym[1] = sof_pkg::BYTE_W'($urandom_range(255));
            case ($urandom_range(2))
                0:       sym[2] = 8'h00;
                1:       sym[2] = 8'hFF;
                default: sym[2] = sof_pkg::BYTE_W'($urandom_range(255));
            endcase
            num_syms = $urandom_range(1, 3);
            for (int i = 0; i < sof_pkg::PAT_BYTES; i++)
            begin
                if ($urandom_range(7) == 0)
                    pat_bytes[i] = sof_pkg::BYTE_W'($urandom_range(255));
                else
                    pat_bytes[i] = sym[$urandom_range(num_syms - 1)];
                if (i < 8)
                    low_word[8*i +: 8] = pat_bytes[i];
                else
                    high_word[8*(i-8) +: 8] = pat_bytes[i];
            end
            write_registers(len_word, low_word, high_word);

            eff_len = (new_len > sof_pkg::PAT_BYTES) ? sof_pkg::PAT_BYTES : new_len;
            if (eff_len == 0)
                eff_len = 3;
            copy_left = 0;
            copy_idx  = 0;
            text_left = $urandom_range(1, 40);
            // the last text of a phase is often cut, so the next pattern lands mid-text
            for (int n = 0; n < 60; n++)
            begin
                if (copy_left == 0 && $urandom_range(9) < 3)
                begin
                    copy_idx  = 0;
                    copy_left = eff_len;
                end
                if (copy_left != 0)
                begin
                    data = pat_bytes[copy_idx];
                    copy_idx++;
                    copy_left--;
                end
                else if ($urandom_range(4) == 0)
                    data = sof_pkg::BYTE_W'($urandom_range(255));
                else
                    data = pat_bytes[$urandom_range(eff_len - 1)];
                text_left--;
                queue_byte(data, text_left == 0);
                if (text_left == 0)
                    text_left = $urandom_range(1, 40);
            end
            wait_quiet();
        end

        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/sof_pkg.sv
rtl/sof_if.sv
rtl/sof_cell.sv
rtl/sof_tracker.sv
rtl/substring_occurrence_finder.sv
tb/substring_occurrence_finder_tb.sv
